FILE: rtl/core/chacha20_fast_key_erasure_rng_top_macros.svh
// Assertion macros shared by the checker of the random byte generator.
`ifndef CHACHA20_FAST_KEY_ERASURE_RNG_TOP_MACROS_SVH
`define CHACHA20_FAST_KEY_ERASURE_RNG_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCRNG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccrng check failed");

// Next-cycle implication, disabled during reset.
`define CCRNG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccrng check failed");

`endif

FILE: rtl/core/ccrng_pkg.sv
// Shared types, constants and ChaCha20 helper functions.
package ccrng_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int MAX_DRAW_DEF     = 64;
  localparam logic [15:0] RESEED_RESET = 16'd16384;
  localparam int KEY_BYTES        = 32;
  localparam int SEED_WORDS       = 11;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [1:0] ACT_SEED  = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_FORCE = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [1:0] ST_BYTE     = 2'd0;
  localparam logic [1:0] ST_SEED_OK  = 2'd1;
  localparam logic [1:0] ST_SEED_BAD = 2'd2;
  localparam logic [1:0] ST_NEED     = 2'd3;

  typedef logic [7:0] waddr_t;

  typedef enum logic [1:0] {
    CMD_SEED  = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_FORCE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
    logic [6:0]  count;
  } cmd_t;

  typedef struct packed {
    logic        wr_en;
    waddr_t      wr_addr;
    logic [31:0] wr_data;
    logic        done;
  } core_out_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // State index of one quarter-round operand; diagonal rounds shift the lane.
  function automatic logic [3:0] qidx(input logic [1:0] q, input logic [1:0] p,
                                      input logic diag);
    logic [1:0] lane;
    lane = diag ? 2'(q + p) : q;
    return {p, lane};
  endfunction

  function automatic logic [31:0] init_word(input logic [3:0] i,
                                            input logic [7:0][31:0] key,
                                            input logic [2:0][31:0] nonce,
                                            input logic [31:0] blk);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'h61707865;
      4'd1:    v = 32'h3320646e;
      4'd2:    v = 32'h79622d32;
      4'd3:    v = 32'h6b206574;
      4'd12:   v = blk;
      4'd13:   v = nonce[0];
      4'd14:   v = nonce[1];
      4'd15:   v = nonce[2];
      default: v = key[3'(i - 4'd4)];
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/ccrng_front.sv
// Front end: accept input items, classify them and push commands.
module ccrng_front #(
  parameter int MAX_DRAW_BYTES = ccrng_pkg::MAX_DRAW_DEF
) (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [38:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              q_full,
  output logic              q_push,
  output ccrng_pkg::cmd_t   q_cmd
);

  logic [6:0] count;
  logic       keep;

  assign count = s_axis_tdata[38:32];
  assign s_axis_tready = !q_full;

  always_comb begin
    q_cmd.word  = s_axis_tdata[31:0];
    q_cmd.count = (count > 7'(MAX_DRAW_BYTES)) ? 7'(MAX_DRAW_BYTES) : count;
    q_cmd.kind  = ccrng_pkg::CMD_SEED;
    keep        = 1'b1;
    case (s_axis_tuser)
      ccrng_pkg::ACT_SEED:  q_cmd.kind = ccrng_pkg::CMD_SEED;
      ccrng_pkg::ACT_DRAW:  begin
        q_cmd.kind = ccrng_pkg::CMD_DRAW;
        keep       = (count != 7'd0);
      end
      ccrng_pkg::ACT_FORCE: q_cmd.kind = ccrng_pkg::CMD_FORCE;
      default:              keep = 1'b0;
    endcase
  end

  // Drop empty draws and the unused action here.
  assign q_push = s_axis_tvalid && s_axis_tready && keep;

endmodule

FILE: rtl/core/ccrng_queue.sv
// Short command queue between front and back.
module ccrng_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ccrng_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ccrng_pkg::cmd_t head
);

  localparam int QA = $clog2(ccrng_pkg::QUEUE_DEPTH);

  ccrng_pkg::cmd_t mem [ccrng_pkg::QUEUE_DEPTH];
  logic [QA-1:0]   wp;
  logic [QA-1:0]   rp;
  logic [QA:0]     cnt;

  assign full  = (cnt == (QA+1)'(ccrng_pkg::QUEUE_DEPTH));
  assign valid = (cnt != '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QA+1)'(push) - (QA+1)'(pop);
    end
  end

endmodule

FILE: rtl/core/ccrng_core.sv
// ChaCha20 block unit: one operation step of all four quarter rounds a cycle.
module ccrng_core #(
  parameter int BLOCKS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [7:0][31:0]     key,
  input  logic [2:0][31:0]     nonce,
  output ccrng_pkg::core_out_t co
);

  localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_OUT   = 3'b100
  } cstate_t;

  cstate_t           state;
  logic [15:0][31:0] w;
  logic [15:0][31:0] w_step;
  logic [15:0][31:0] w_init;
  logic [BW-1:0]     blk;
  logic [BW-1:0]     blk_load;
  logic [4:0]        rnd;
  logic [1:0]        sub;
  logic [3:0]        idx;

  // Start state of the block about to run.
  assign blk_load = (state == C_IDLE) ? '0 : BW'(blk + 1'b1);
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_init[i] = ccrng_pkg::init_word(4'(i), key, nonce, 32'(blk_load));
    end
  end

  // One add, xor and rotate per quarter round; the four lanes are disjoint.
  always_comb begin
    logic [3:0]  ai, bi, ci, di;
    logic [31:0] s;
    w_step = w;
    for (int q = 0; q < 4; q++) begin
      ai = ccrng_pkg::qidx(2'(q), 2'd0, rnd[0]);
      bi = ccrng_pkg::qidx(2'(q), 2'd1, rnd[0]);
      ci = ccrng_pkg::qidx(2'(q), 2'd2, rnd[0]);
      di = ccrng_pkg::qidx(2'(q), 2'd3, rnd[0]);
      case (sub)
        2'd0: begin
          s = w[ai] + w[bi];
          w_step[ai] = s;
          w_step[di] = ccrng_pkg::rotl(w[di] ^ s, 16);
        end
        2'd1: begin
          s = w[ci] + w[di];
          w_step[ci] = s;
          w_step[bi] = ccrng_pkg::rotl(w[bi] ^ s, 12);
        end
        2'd2: begin
          s = w[ai] + w[bi];
          w_step[ai] = s;
          w_step[di] = ccrng_pkg::rotl(w[di] ^ s, 8);
        end
        default: begin
          s = w[ci] + w[di];
          w_step[ci] = s;
          w_step[bi] = ccrng_pkg::rotl(w[bi] ^ s, 7);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE:  if (start) state <= C_ROUND;
        C_ROUND: if (rnd == 5'd19 && sub == 2'd3) state <= C_OUT;
        C_OUT:   if (idx == 4'd15) state <= (blk == BW'(BLOCKS - 1)) ? C_IDLE : C_ROUND;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        w   <= w_init;
        blk <= '0;
        rnd <= '0;
        sub <= '0;
        idx <= '0;
      end
      C_ROUND: begin
        w   <= w_step;
        sub <= sub + 1'b1;
        if (sub == 2'd3) rnd <= rnd + 1'b1;
        idx <= '0;
      end
      C_OUT: begin
        idx <= idx + 1'b1;
        if (idx == 4'd15) begin
          w   <= w_init;
          blk <= blk_load;
          rnd <= '0;
          sub <= '0;
        end
      end
      default: idx <= '0;
    endcase
  end

  assign co.wr_en   = (state == C_OUT);
  assign co.wr_addr = ccrng_pkg::waddr_t'({blk, idx});
  assign co.wr_data = w[idx] + ccrng_pkg::init_word(idx, key, nonce, 32'(blk));
  assign co.done    = (state == C_OUT) && (idx == 4'd15) && (blk == BW'(BLOCKS - 1));

endmodule

FILE: rtl/core/ccrng_back.sv
// Back end: seed staging, reseed policy, keystream buffer and result register.
module ccrng_back #(
  parameter int BUFFER_BYTES = ccrng_pkg::BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 cmd_valid,
  input  ccrng_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 core_start,
  output logic [7:0][31:0]     key,
  output logic [2:0][31:0]     nonce,
  input  ccrng_pkg::core_out_t co,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  localparam int MEM_WORDS = (BUFFER_BYTES + 3) / 4;
  localparam int MA        = $clog2(MEM_WORDS);
  localparam int PW        = $clog2(BUFFER_BYTES) + 1;

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_CHECK  = 5'b00010,
    B_REFILL = 5'b00100,
    B_READ   = 5'b01000,
    B_RESULT = 5'b10000
  } bstate_t;

  bstate_t          state;
  logic [15:0]      interval;
  logic [31:0]      staged [ccrng_pkg::SEED_WORDS];
  logic [3:0]       seed_idx;
  logic             fresh;
  logic [7:0][31:0] new_key;
  logic [PW-1:0]    pos;
  logic [6:0]       remain;
  logic [15:0]      rc;
  logic [1:0]       res_status;
  logic [31:0]      rd;
  logic [31:0]      mem [MEM_WORDS];
  logic [16:0]      r;
  logic [16:0]      n;
  logic [4:0]       rcnt;
  logic [16:0]      r_sh;
  logic             empty;
  logic             slot_free;
  logic             key_zero;
  logic             nonce_zero;
  logic [7:0]       sel_byte;

  assign empty     = (pos == PW'(BUFFER_BYTES));
  assign slot_free = !m_tvalid || m_tready;
  assign cmd_pop   = (state == B_IDLE) && cmd_valid;

  always_comb begin
    key_zero = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (staged[i] != '0) key_zero = 1'b0;
    end
    nonce_zero = (staged[8] == '0) && (staged[9] == '0) && (cmd.word == '0);
  end

  always_comb begin
    case (pos[1:0])
      2'd0:    sel_byte = rd[7:0];
      2'd1:    sel_byte = rd[15:8];
      2'd2:    sel_byte = rd[23:16];
      default: sel_byte = rd[31:24];
    endcase
  end

  // Keystream buffer; bytes below the key area are written but never read.
  always_ff @(posedge clk) begin
    if (co.wr_en && (int'(co.wr_addr) < MEM_WORDS)) begin
      mem[co.wr_addr[MA-1:0]] <= co.wr_data;
    end
    if (state == B_CHECK && !empty) begin
      rd <= mem[pos[MA+1:2]];
    end
  end

  // Next refill counter: (count + 1) mod interval, one quotient bit a cycle.
  assign r_sh = {r[15:0], n[16]};
  always_ff @(posedge clk) begin
    if (core_start) begin
      n    <= 17'(rc) + 17'd1;
      r    <= '0;
      rcnt <= 5'd17;
    end else if (rcnt != '0) begin
      n    <= {n[15:0], 1'b0};
      r    <= (r_sh >= 17'(interval)) ? r_sh - 17'(interval) : r_sh;
      rcnt <= rcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval   <= ccrng_pkg::RESEED_RESET;
      state      <= B_IDLE;
      seed_idx   <= '0;
      fresh      <= 1'b0;
      pos        <= PW'(BUFFER_BYTES);
      rc         <= '0;
      core_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) interval <= cfg_wdata;
      core_start <= (state == B_CHECK) && empty && (rc != '0 || fresh);
      if ((state == B_READ || state == B_RESULT) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              ccrng_pkg::CMD_SEED: begin
                if (seed_idx == 4'd0) fresh <= 1'b0;
                if (seed_idx == 4'(ccrng_pkg::SEED_WORDS - 1)) begin
                  seed_idx <= '0;
                  if (key_zero || nonce_zero) begin
                    res_status <= ccrng_pkg::ST_SEED_BAD;
                  end else begin
                    res_status <= ccrng_pkg::ST_SEED_OK;
                    fresh      <= 1'b1;
                  end
                end else begin
                  seed_idx   <= seed_idx + 1'b1;
                  res_status <= ccrng_pkg::ST_SEED_OK;
                end
                state <= B_RESULT;
              end
              ccrng_pkg::CMD_DRAW: begin
                remain <= cmd.count;
                state  <= B_CHECK;
              end
              ccrng_pkg::CMD_FORCE: begin
                pos <= PW'(BUFFER_BYTES);
                rc  <= '0;
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_CHECK: begin
          if (!empty) begin
            state <= B_READ;
          end else if (rc == '0 && !fresh) begin
            res_status <= ccrng_pkg::ST_NEED;
            state      <= B_RESULT;
          end else begin
            if (rc == '0) fresh <= 1'b0;
            state <= B_REFILL;
          end
        end
        B_REFILL: begin
          if (co.done) begin
            pos   <= PW'(ccrng_pkg::KEY_BYTES);
            rc    <= (interval == '0) ? rc + 16'd1 : r[15:0];
            state <= B_CHECK;
          end
        end
        B_READ: begin
          if (slot_free) begin
            pos    <= pos + 1'b1;
            remain <= remain - 1'b1;
            state  <= (remain == 7'd1) ? B_IDLE : B_CHECK;
          end
        end
        B_RESULT: begin
          if (slot_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Payload registers: staging set, key, nonce and the result item.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && cmd_valid && cmd.kind == ccrng_pkg::CMD_SEED) begin
      staged[seed_idx] <= cmd.word;
    end
    if (state == B_CHECK && empty && rc == '0 && fresh) begin
      for (int i = 0; i < 8; i++) key[i] <= staged[i];
      for (int i = 0; i < 3; i++) nonce[i] <= staged[8 + i];
    end
    if (co.wr_en && co.wr_addr < ccrng_pkg::waddr_t'(8)) begin
      new_key[co.wr_addr[2:0]] <= co.wr_data;
    end
    if (state == B_REFILL && co.done) begin
      key <= new_key;
    end
    if (state == B_READ && slot_free) begin
      m_tdata <= sel_byte;
      m_tuser <= ccrng_pkg::ST_BYTE;
      m_tlast <= (remain == 7'd1);
    end
    if (state == B_RESULT && slot_free) begin
      m_tdata <= '0;
      m_tuser <= res_status;
      m_tlast <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/chacha20_fast_key_erasure_rng_top.sv
// A seed word gives its result through the queue and the B_RESULT state when the back end is idle.
// A draw reads its bytes one at a time through the B_CHECK and B_READ states from the buffer read port.
// An empty buffer costs one refill of (BUFFER_BYTES+63)/64 blocks of the ChaCha20 unit,
// once every BUFFER_BYTES - 32 bytes handed out (224 at 256 bytes).
// Reset (rst, synchronous) empties the buffer, clears seed state and counters,
// and sets reseed_interval to 16384; no clearing pass is needed.
module chacha20_fast_key_erasure_rng_top #(
  parameter int BUFFER_BYTES   = ccrng_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_DRAW_BYTES = ccrng_pkg::MAX_DRAW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Reseed interval register write.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // seed_word[31:0], byte_count[38:32], zero[39]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // random_byte[7:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast   // last
);

  localparam int BLOCKS = (BUFFER_BYTES + 63) / 64;

  logic                 q_full;
  logic                 q_push;
  ccrng_pkg::cmd_t      q_cmd;
  logic                 q_pop;
  logic                 q_valid;
  ccrng_pkg::cmd_t      q_head;
  logic                 core_start;
  logic [7:0][31:0]     key;
  logic [2:0][31:0]     nonce;
  ccrng_pkg::core_out_t co;

  // Classify items and drop the ones that cause nothing.
  ccrng_front #(
    .MAX_DRAW_BYTES(MAX_DRAW_BYTES)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata[38:0]),
    .s_axis_tuser (s_axis_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Hold commands while the back end refills or waits on the output.
  ccrng_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // Execute commands, own the buffer and the result register.
  ccrng_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .core_start(core_start),
    .key       (key),
    .nonce     (nonce),
    .co        (co),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .m_tlast   (m_axis_tlast)
  );

  // Generate the refill blocks, counter 0 upward, one word written a cycle in the output state.
  ccrng_core #(
    .BLOCKS(BLOCKS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .start(core_start),
    .key  (key),
    .nonce(nonce),
    .co   (co)
  );

endmodule

FILE: rtl/core/ccrng_checker.sv
// Port-level checker for the random byte generator, bound to the top level.
`include "chacha20_fast_key_erasure_rng_top_macros.svh"

module ccrng_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `CCRNG_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `CCRNG_ASSERT_NOW(a_status_last, clk, rst, m_axis_tvalid && m_axis_tuser != ccrng_pkg::ST_BYTE, m_axis_tlast)
  `CCRNG_ASSERT_NOW(a_status_zero, clk, rst, m_axis_tvalid && m_axis_tuser != ccrng_pkg::ST_BYTE, m_axis_tdata == 8'd0)

endmodule

bind chacha20_fast_key_erasure_rng_top ccrng_checker u_ccrng_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
